FILE: rtl/dcps_pkg.sv
// ----------------------------------------------------------------------------
// dcps_pkg: shared types and constants for the DTMF code polarity switch
// Field widths, register indexes, event codes, line bit positions and
// register reset values used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcps_pkg;

    // Field widths
    localparam int CODE_W    = 20;
    localparam int DELAY_W   = 8;
    localparam int DIGIT_W   = 4;
    localparam int CNT_W     = 3;
    localparam int EVENT_W   = 3;
    localparam int LINES_W   = 4;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_CODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INHIBIT_DELAY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_DELAY  = 3'd4;

    // Register reset values
    localparam logic [CODE_W-1:0]  RST_FIRST_CODE    = 20'h12345;
    localparam logic [CODE_W-1:0]  RST_SECOND_CODE   = 20'h54321;
    localparam logic [DELAY_W-1:0] RST_DIGIT_TIMEOUT = 8'd30;
    localparam logic [DELAY_W-1:0] RST_INHIBIT_DELAY = 8'd5;
    localparam logic [DELAY_W-1:0] RST_SWITCH_DELAY  = 8'd10;

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_DIGIT    = 3'd1;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_MISMATCH = 3'd3;
    localparam logic [EVENT_W-1:0] EV_FIRST    = 3'd4;
    localparam logic [EVENT_W-1:0] EV_SECOND   = 3'd5;
    localparam logic [EVENT_W-1:0] EV_ALREADY  = 3'd6;
    localparam logic [EVENT_W-1:0] EV_SWITCHED = 3'd7;

    // Bit positions in the line vector
    localparam int LN_FIRST   = 0;
    localparam int LN_SECOND  = 1;
    localparam int LN_INHIBIT = 2;
    localparam int LN_RELAY   = 3;

    // Reset value of the line vector: second enable on
    localparam logic [LINES_W-1:0] RST_LINES = 4'b0010;

    // Configuration set handed to the sequencer
    typedef struct packed {
        logic [CODE_W-1:0]  first_code;
        logic [CODE_W-1:0]  second_code;
        logic [DELAY_W-1:0] digit_timeout;
        logic [DELAY_W-1:0] inhibit_delay;
        logic [DELAY_W-1:0] switch_delay;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [CNT_W-1:0]   digits_held;
        logic [LINES_W-1:0] lines;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/dcps_cfg.sv
// ----------------------------------------------------------------------------
// dcps_cfg: configuration register file
// Holds the two codes and the three tick limits; written one register per
// transaction on the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dcps_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [dcps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dcps_pkg::CODE_W-1:0]    i_cfg_data,
    output dcps_pkg::t_cfg                      o_cfg
);

    dcps_pkg::t_cfg r_cfg;

    // Always able to take a write
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Update the addressed register; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_code    <= dcps_pkg::RST_FIRST_CODE;
            r_cfg.second_code   <= dcps_pkg::RST_SECOND_CODE;
            r_cfg.digit_timeout <= dcps_pkg::RST_DIGIT_TIMEOUT;
            r_cfg.inhibit_delay <= dcps_pkg::RST_INHIBIT_DELAY;
            r_cfg.switch_delay  <= dcps_pkg::RST_SWITCH_DELAY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dcps_pkg::REG_FIRST_CODE:    r_cfg.first_code  <= i_cfg_data;
                dcps_pkg::REG_SECOND_CODE:   r_cfg.second_code <= i_cfg_data;
                dcps_pkg::REG_DIGIT_TIMEOUT: begin
                    r_cfg.digit_timeout <= i_cfg_data[dcps_pkg::DELAY_W-1:0];
                end
                dcps_pkg::REG_INHIBIT_DELAY: begin
                    r_cfg.inhibit_delay <= i_cfg_data[dcps_pkg::DELAY_W-1:0];
                end
                dcps_pkg::REG_SWITCH_DELAY: begin
                    r_cfg.switch_delay <= i_cfg_data[dcps_pkg::DELAY_W-1:0];
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dcps_seq.sv
// ----------------------------------------------------------------------------
// dcps_seq: digit collector and switching sequencer
// Holds the entry, tick counter, phase and output lines, and works out the
// next state and the result for one transaction in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dcps_seq #(
    parameter int CODE_DIGITS = 5
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic                         i_cmd,
    input  wire logic [dcps_pkg::DIGIT_W-1:0] i_digit,
    input  wire dcps_pkg::t_cfg               i_cfg,
    output dcps_pkg::t_result                 o_result
);

    localparam int STORE_W = dcps_pkg::DIGIT_W * CODE_DIGITS;
    localparam logic [dcps_pkg::CNT_W-1:0] LAST_CNT = dcps_pkg::CNT_W'(CODE_DIGITS - 1);

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_INHIBIT,
        PH_SWITCH
    } t_phase;

    typedef struct packed {
        t_phase                           phase;
        logic [dcps_pkg::DELAY_W-1:0]     tick;
        logic [dcps_pkg::LINES_W-1:0]     lines;
        logic                             done;
    } t_adv;

    // Run the inhibit and switch waits as far as the tick count allows
    function automatic t_adv advance(
        input t_phase                       phase,
        input logic [dcps_pkg::DELAY_W-1:0] tick,
        input logic [dcps_pkg::LINES_W-1:0] lines,
        input logic                         tgt,
        input logic [dcps_pkg::DELAY_W-1:0] inh_delay,
        input logic [dcps_pkg::DELAY_W-1:0] sw_delay
    );
        t_adv a;
        a.phase = phase;
        a.tick  = tick;
        a.lines = lines;
        a.done  = 1'b0;
        if (a.phase == PH_INHIBIT && a.tick >= inh_delay) begin
            a.tick = '0;
            if (tgt) begin
                a.lines[dcps_pkg::LN_FIRST] = 1'b0;
            end else begin
                a.lines[dcps_pkg::LN_SECOND] = 1'b0;
            end
            a.lines[dcps_pkg::LN_RELAY] = 1'b1;
            a.phase = PH_SWITCH;
        end
        if (a.phase == PH_SWITCH && a.tick >= sw_delay) begin
            if (tgt) begin
                a.lines[dcps_pkg::LN_SECOND] = 1'b1;
            end else begin
                a.lines[dcps_pkg::LN_FIRST] = 1'b1;
            end
            a.phase = PH_COLLECT;
            a.tick  = '0;
            a.done  = 1'b1;
        end
        return a;
    endfunction

    t_phase                         r_phase, n_phase;
    logic [STORE_W-1:0]             r_store, n_store;
    logic [dcps_pkg::CNT_W-1:0]     r_cnt,   n_cnt;
    logic [dcps_pkg::DELAY_W-1:0]   r_tick,  n_tick;
    logic                           r_tgt,   n_tgt;
    logic [dcps_pkg::LINES_W-1:0]   r_lines, n_lines;
    logic [dcps_pkg::EVENT_W-1:0]   n_event;

    logic [dcps_pkg::DELAY_W-1:0]   tick_inc;
    logic [STORE_W-1:0]             shifted;
    logic                           hit_first;
    logic                           hit_second;
    logic                           line_on;
    t_adv                           adv_tick;
    t_adv                           adv_match;

    // Saturating tick increment and the entry with the new digit shifted in
    assign tick_inc   = (r_tick == '1) ? r_tick : r_tick + 1'b1;
    assign shifted    = STORE_W'({r_store, i_digit});
    assign hit_first  = (shifted == STORE_W'(i_cfg.first_code));
    assign hit_second = (shifted == STORE_W'(i_cfg.second_code));
    assign line_on    = hit_first ? r_lines[dcps_pkg::LN_FIRST] : r_lines[dcps_pkg::LN_SECOND];

    // Sequence step on a tick, and the sequence start right after a match
    always_comb begin
        logic [dcps_pkg::LINES_W-1:0] start_lines;
        start_lines = r_lines;
        start_lines[dcps_pkg::LN_INHIBIT] = 1'b1;
        adv_tick  = advance(r_phase, tick_inc, r_lines, r_tgt,
                            i_cfg.inhibit_delay, i_cfg.switch_delay);
        adv_match = advance(PH_INHIBIT, '0, start_lines, !hit_first,
                            i_cfg.inhibit_delay, i_cfg.switch_delay);
    end

    // Next state and event for one transaction
    always_comb begin
        n_phase = r_phase;
        n_store = r_store;
        n_cnt   = r_cnt;
        n_tick  = r_tick;
        n_tgt   = r_tgt;
        n_lines = r_lines;
        n_event = dcps_pkg::EV_NONE;
        if (i_cmd) begin
            case (r_phase)
                PH_COLLECT: begin
                    n_tick = tick_inc;
                    if (r_cnt != '0 && tick_inc >= i_cfg.digit_timeout) begin
                        n_store = '0;
                        n_cnt   = '0;
                        n_tick  = '0;
                        n_event = dcps_pkg::EV_TIMEOUT;
                    end
                end
                PH_INHIBIT, PH_SWITCH: begin
                    n_phase = adv_tick.phase;
                    n_tick  = adv_tick.tick;
                    n_lines = adv_tick.lines;
                    if (adv_tick.done) begin
                        n_event = dcps_pkg::EV_SWITCHED;
                    end
                end
                default: ;
            endcase
        end else if (r_phase == PH_COLLECT && i_digit != '0) begin
            n_tick = '0;
            if (r_cnt != LAST_CNT) begin
                n_store = shifted;
                n_cnt   = r_cnt + 1'b1;
                n_event = dcps_pkg::EV_DIGIT;
            end else begin
                // Entry complete: compare, first code wins a tie
                n_store = '0;
                n_cnt   = '0;
                if (!hit_first && !hit_second) begin
                    n_event = dcps_pkg::EV_MISMATCH;
                end else begin
                    n_tgt = !hit_first;
                    if (line_on) begin
                        n_event = dcps_pkg::EV_ALREADY;
                    end else begin
                        n_phase = adv_match.phase;
                        n_tick  = adv_match.tick;
                        n_lines = adv_match.lines;
                        if (adv_match.done) begin
                            n_event = dcps_pkg::EV_SWITCHED;
                        end else if (hit_first) begin
                            n_event = dcps_pkg::EV_FIRST;
                        end else begin
                            n_event = dcps_pkg::EV_SECOND;
                        end
                    end
                end
            end
        end
    end

    assign o_result.event_res   = n_event;
    assign o_result.digits_held = n_cnt;
    assign o_result.lines       = n_lines;

    // Hold state; advance on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COLLECT;
            r_store <= '0;
            r_cnt   <= '0;
            r_tick  <= '0;
            r_tgt   <= 1'b0;
            r_lines <= dcps_pkg::RST_LINES;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_store <= n_store;
            r_cnt   <= n_cnt;
            r_tick  <= n_tick;
            r_tgt   <= n_tgt;
            r_lines <= n_lines;
        end
    end

    // Inhibit is up whenever a switching sequence runs
    a_inhibit_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_COLLECT |-> r_lines[dcps_pkg::LN_INHIBIT])
        else $error("switching sequence without inhibit");

    // The two enables are never on together
    a_enables_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_lines[dcps_pkg::LN_FIRST] && r_lines[dcps_pkg::LN_SECOND]))
        else $error("both enables on");

    // No digits pend while switching
    a_no_digits_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_COLLECT |-> r_cnt == '0)
        else $error("digits held during switching");

    // Digit count stays below a full entry
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LAST_CNT)
        else $error("digit count out of range");

endmodule

`default_nettype wire

FILE: rtl/dtmf_code_polarity_switch_core.sv
// ----------------------------------------------------------------------------
// dtmf_code_polarity_switch_core: DTMF code polarity switch, top level
// Collects digit codes, matches full entries against two codes and steps
// the inhibit / relay / enable switching sequence on timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser = cmd (0 digit strobe, 1 timer tick), tdata[3:0] =
//   digit code. Every input transaction yields exactly one result transaction
//   carrying the four output lines, the digits held and an event code.
//   The result register loads at the edge that accepts the input.
//   Throughput is one transaction per cycle while results are taken; the whole
//   state update is one pass of logic between the state and result registers.
//   While the receiver stalls, a pending result holds and the input side takes
//   no new transaction until that result is taken; with the result taken in
//   the same cycle, input continues without a gap.
//   Reset (synchronous, active low) loads the default codes and delays,
//   clears the entry and tick counter, turns on the second enable only and
//   empties the result register.
//   Configuration writes take effect at the edge that accepts them; the user
//   must make them while the stream is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module dtmf_code_polarity_switch_core #(
    parameter int CODE_DIGITS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [3:0] digit, [7:4] zero
    input  wire logic        i_s_axis_tuser,   // [0] cmd
    // Result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [0] first_enable, [1] second_enable,
                                               // [2] inhibit_line, [3] relay_disable,
                                               // [6:4] digits_held, [9:7] event_res,
                                               // [15:10] zero
    // Configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dcps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dcps_pkg::CODE_W-1:0]     i_cfg_data
);

    dcps_pkg::t_cfg    cfg;
    dcps_pkg::t_result result;
    logic              in_accept;
    logic              cfg_write;

    logic              r_out_valid;
    dcps_pkg::t_result r_out;

    // Take a new transaction when the result register is free or draining
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_write       = i_cfg_valid && o_cfg_ready;

    dcps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dcps_seq #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_accept),
        .i_cmd    (i_s_axis_tuser),
        .i_digit  (i_s_axis_tdata[dcps_pkg::DIGIT_W-1:0]),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.event_res, r_out.digits_held, r_out.lines};

    // An accepted transaction always leaves a result pending
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction left no result");

    // Configuration is written only with no result pending
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_write |-> !r_out_valid && !in_accept)
        else $error("configuration write while busy");

    // A stalled result is not overwritten
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |-> !in_accept)
        else $error("stalled result overwritten");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level check of the DTMF code polarity switch core
// Drives digit strobes and timer ticks into the input stream and compares
// every result transaction, field by field, with an in-bench model of the
// entry collector and the inhibit / relay / enable sequencer, or with the
// result typed into a short table of opening items, which come first.
// Random traffic follows under several register settings, the extremes
// among them. Both stream sides stall at random.
// ----------------------------------------------------------------------------

module testbench;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TARGET_ITEMS = 1550;
    localparam int SETTLE_GAP   = 3;

    // Phase of the switching sequence as the bench tracks it
    typedef enum logic [1:0] {
        SEQ_COLLECT,
        SEQ_INHIBIT,
        SEQ_SWITCH
    } t_seq_phase;

    // One result item, lines packed as {relay, inhibit, second, first}
    typedef struct packed {
        logic [dcps_pkg::EVENT_W-1:0] ev;
        logic [dcps_pkg::CNT_W-1:0]   held;
        logic                         relay_off;
        logic                         inhibit_on;
        logic                         second_en;
        logic                         first_en;
    } t_line_report;

    // Row of the opening table: cmd, digit, whether a result is typed in, result
    typedef struct packed {
        logic         cmd;
        logic [3:0]   dig;
        logic         typed;
        t_line_report want;
    } t_opening_row;

    // Opening items, run on the reset register values
    localparam t_opening_row OPENING [21] = '{
        {1'b1, 4'h3, 1'b1, dcps_pkg::EV_NONE,     3'd0, 4'b0010}, // tick, nothing pending
        {1'b0, 4'h0, 1'b1, dcps_pkg::EV_NONE,     3'd0, 4'b0010}, // digit code zero
        {1'b0, 4'hF, 1'b1, dcps_pkg::EV_DIGIT,    3'd1, 4'b0010},
        {1'b1, 4'hA, 1'b0, 10'd0},
        {1'b0, 4'h0, 1'b0, 10'd0},                                // zero inside an entry
        {1'b0, 4'hF, 1'b0, 10'd0},
        {1'b0, 4'hF, 1'b0, 10'd0},
        {1'b0, 4'hF, 1'b0, 10'd0},
        {1'b0, 4'hF, 1'b1, dcps_pkg::EV_MISMATCH, 3'd0, 4'b0010},
        {1'b0, 4'h5, 1'b1, dcps_pkg::EV_DIGIT,    3'd1, 4'b0010},
        {1'b0, 4'h4, 1'b0, 10'd0},
        {1'b0, 4'h3, 1'b0, 10'd0},
        {1'b0, 4'h2, 1'b0, 10'd0},
        {1'b0, 4'h1, 1'b1, dcps_pkg::EV_ALREADY,  3'd0, 4'b0010}, // second is on from reset
        {1'b0, 4'h1, 1'b0, 10'd0},
        {1'b0, 4'h2, 1'b0, 10'd0},
        {1'b0, 4'h3, 1'b0, 10'd0},
        {1'b0, 4'h4, 1'b0, 10'd0},
        {1'b0, 4'h5, 1'b1, dcps_pkg::EV_FIRST,    3'd0, 4'b0110}, // inhibit raised
        {1'b0, 4'h8, 1'b1, dcps_pkg::EV_NONE,     3'd0, 4'b0110}, // digit while switching
        {1'b1, 4'h0, 1'b0, 10'd0}
    };

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic [7:0]                     in_data   = '0;
    logic                           in_cmd    = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [15:0]                    out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [dcps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dcps_pkg::CODE_W-1:0]    cfg_data  = '0;

    // Bench copy of the registers and the sequencer state
    logic [dcps_pkg::CODE_W-1:0]    cfg_first;
    logic [dcps_pkg::CODE_W-1:0]    cfg_second;
    logic [dcps_pkg::DELAY_W-1:0]   cfg_timeout;
    logic [dcps_pkg::DELAY_W-1:0]   cfg_inhibit;
    logic [dcps_pkg::DELAY_W-1:0]   cfg_switch;
    t_seq_phase                     seq_phase;
    logic [dcps_pkg::CODE_W-1:0]    entry_digits;
    logic [dcps_pkg::CNT_W-1:0]     entry_count;
    logic [dcps_pkg::DELAY_W-1:0]   ticks_seen;
    logic                           aim_second;
    logic [dcps_pkg::LINES_W-1:0]   line_bits;

    t_line_report         line_reports_due [$];
    t_line_report         report_due;
    int                   fault_count   = 0;
    int                   steps_done    = 0;
    int                   src_idle_pct  = 0;
    int                   dst_idle_pct  = 0;
    int                   watch_cycles;

    dtmf_code_polarity_switch_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_cmd),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // Step the switching sequence while its waits are over; 1 when the
    // matched enable has just come up
    function automatic bit advance_sequence();
        if (seq_phase == SEQ_INHIBIT && ticks_seen >= cfg_inhibit) begin
            ticks_seen = '0;
            line_bits[aim_second ? dcps_pkg::LN_FIRST : dcps_pkg::LN_SECOND] = 1'b0;
            line_bits[dcps_pkg::LN_RELAY] = 1'b1;
            seq_phase = SEQ_SWITCH;
        end
        if (seq_phase == SEQ_SWITCH && ticks_seen >= cfg_switch) begin
            line_bits[aim_second ? dcps_pkg::LN_SECOND : dcps_pkg::LN_FIRST] = 1'b1;
            seq_phase = SEQ_COLLECT;
            ticks_seen = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Compare a full entry with both codes and start switching on a match
    function automatic logic [dcps_pkg::EVENT_W-1:0] close_entry();
        logic [dcps_pkg::CODE_W-1:0] entry;
        int                          sel_line;
        entry        = entry_digits;
        entry_digits = '0;
        entry_count  = '0;
        if (entry == cfg_first) begin
            aim_second = 1'b0;
            sel_line   = dcps_pkg::LN_FIRST;
        end else if (entry == cfg_second) begin
            aim_second = 1'b1;
            sel_line   = dcps_pkg::LN_SECOND;
        end else begin
            return dcps_pkg::EV_MISMATCH;
        end
        if (line_bits[sel_line])
            return dcps_pkg::EV_ALREADY;
        line_bits[dcps_pkg::LN_INHIBIT] = 1'b1;
        ticks_seen = '0;
        seq_phase  = SEQ_INHIBIT;
        if (advance_sequence())
            return dcps_pkg::EV_SWITCHED;
        return aim_second ? dcps_pkg::EV_SECOND : dcps_pkg::EV_FIRST;
    endfunction

    // Work out the result of one input transaction and update the bench state
    function automatic t_line_report forecast_switch_step(input logic cmd,
                                                          input logic [3:0] dig,
                                                          output bit skipped);
        logic [dcps_pkg::EVENT_W-1:0] ev;
        ev      = dcps_pkg::EV_NONE;
        skipped = 1'b0;
        if (cmd) begin
            if (ticks_seen != 8'hFF)
                ticks_seen = ticks_seen + 8'd1;
            if (seq_phase == SEQ_COLLECT) begin
                if (entry_count != 0 && ticks_seen >= cfg_timeout) begin
                    entry_digits = '0;
                    entry_count  = '0;
                    ticks_seen   = '0;
                    ev           = dcps_pkg::EV_TIMEOUT;
                end
            end else if (advance_sequence()) begin
                ev = dcps_pkg::EV_SWITCHED;
            end
        end else if (seq_phase == SEQ_COLLECT && dig != 4'h0) begin
            ticks_seen   = '0;
            entry_digits = {entry_digits[dcps_pkg::CODE_W-5:0], dig};
            entry_count  = entry_count + 3'd1;
            ev           = dcps_pkg::EV_DIGIT;
            if (entry_count >= 3'd5)
                ev = close_entry();
        end else begin
            skipped = 1'b1;
        end
        return {ev, entry_count, line_bits};
    endfunction

    task automatic check_field(input string field_name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
            fault_count++;
        end
    endtask

    // Result side: check each accepted transaction, stall at random
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (line_reports_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, out_data);
                fault_count++;
            end else begin
                report_due = line_reports_due.pop_front();
                check_field("first_enable",  report_due.first_en,   out_data[0]);
                check_field("second_enable", report_due.second_en,  out_data[1]);
                check_field("inhibit_line",  report_due.inhibit_on, out_data[2]);
                check_field("relay_disable", report_due.relay_off,  out_data[3]);
                check_field("digits_held",   report_due.held,       out_data[6:4]);
                check_field("event_res",     report_due.ev,         out_data[9:7]);
            end
        end
        out_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Offer one input transaction, hold it until taken, then predict it
    task automatic send_item(input logic cmd, input logic [3:0] dig,
                             input bit typed, input t_line_report want);
        t_line_report forecast;
        bit           skipped;
        if (steps_done < TARGET_ITEMS / 3) begin
            src_idle_pct = 26;
            dst_idle_pct = 53;
        end else if (steps_done < 2 * TARGET_ITEMS / 3) begin
            src_idle_pct = 53;
            dst_idle_pct = 26;
        end else begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_data  <= {4'b0000, dig};
        do @(posedge clk); while (!in_ready);
        forecast = forecast_switch_step(cmd, dig, skipped);
        line_reports_due.push_back(typed ? want : forecast);
        if (!skipped)
            steps_done++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(1'b1, 4'($urandom_range(15)), 1'b0, '0);
    endtask

    // Drop valid, let every result come back, then let the block settle
    task automatic drain_stream();
        in_valid <= 1'b0;
        while (line_reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    // One configuration transaction; valid stays up for a following write
    task automatic write_reg(input logic [dcps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dcps_pkg::CODE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            dcps_pkg::REG_FIRST_CODE:    cfg_first   = value;
            dcps_pkg::REG_SECOND_CODE:   cfg_second  = value;
            dcps_pkg::REG_DIGIT_TIMEOUT: cfg_timeout = value[dcps_pkg::DELAY_W-1:0];
            dcps_pkg::REG_INHIBIT_DELAY: cfg_inhibit = value[dcps_pkg::DELAY_W-1:0];
            dcps_pkg::REG_SWITCH_DELAY:  cfg_switch  = value[dcps_pkg::DELAY_W-1:0];
            default: ;
        endcase
    endtask

    // Idle the stream and load a full register setting, plus one unused index
    task automatic settle(input logic [dcps_pkg::CODE_W-1:0] code_a,
                          input logic [dcps_pkg::CODE_W-1:0] code_b,
                          input logic [dcps_pkg::DELAY_W-1:0] tmo,
                          input logic [dcps_pkg::DELAY_W-1:0] inh,
                          input logic [dcps_pkg::DELAY_W-1:0] sw);
        drain_stream();
        write_reg(dcps_pkg::REG_FIRST_CODE, code_a);
        write_reg(dcps_pkg::REG_DIGIT_TIMEOUT, {12'($urandom_range(4095)), tmo});
        write_reg(dcps_pkg::REG_SWITCH_DELAY + 3'($urandom_range(1, 3)), 20'($urandom));
        write_reg(dcps_pkg::REG_SECOND_CODE, code_b);
        write_reg(dcps_pkg::REG_INHIBIT_DELAY, {12'($urandom_range(4095)), inh});
        write_reg(dcps_pkg::REG_SWITCH_DELAY, {12'($urandom_range(4095)), sw});
        cfg_valid <= 1'b0;
    endtask

    // Five digits, none of them zero
    function automatic logic [dcps_pkg::CODE_W-1:0] draw_code();
        logic [dcps_pkg::CODE_W-1:0] code;
        for (int i = 0; i < 5; i++)
            code[4*i +: 4] = 4'($urandom_range(1, 15));
        return code;
    endfunction

    // Ticks between two digits: mostly none or one, now and then the timeout or one less
    function automatic int digit_gap();
        if ($urandom_range(9) == 0)
            return int'(cfg_timeout) - int'($urandom_range(1));
        return $urandom_range(1);
    endfunction

    // One burst of traffic: a full entry, a partial entry, or loose items
    task automatic gen_burst();
        int                          pick;
        int                          count;
        logic [dcps_pkg::CODE_W-1:0] code;
        pick = $urandom_range(99);
        if (pick < 55) begin
            code = ($urandom_range(1) == 1) ? cfg_second : cfg_first;
            if (pick < 15)
                code = draw_code();
            for (int i = 4; i >= 0; i--) begin
                send_ticks(digit_gap());
                send_item(1'b0, code[4*i +: 4], 1'b0, '0);
            end
            // wait out the sequence, or cut it short so digits land inside it
            count = int'(cfg_inhibit) + int'(cfg_switch);
            if ($urandom_range(3) == 0)
                count = $urandom_range(0, count);
            else
                count += $urandom_range(3);
            send_ticks(count);
        end else if (pick < 75) begin
            repeat ($urandom_range(1, 4)) begin
                send_ticks(digit_gap());
                send_item(1'b0, 4'($urandom_range(1, 15)), 1'b0, '0);
            end
            send_ticks(int'(cfg_timeout) - int'($urandom_range(1)));
        end else begin
            repeat ($urandom_range(1, 6))
                send_item(1'($urandom_range(1)), 4'($urandom_range(15)), 1'b0, '0);
        end
    endtask

    task automatic run_traffic(input int quota);
        int start;
        start = steps_done;
        while (steps_done - start < quota)
            gen_burst();
    endtask

    // Run limit
    initial begin
        for (watch_cycles = 0; watch_cycles < LIMIT_CYCLES; watch_cycles++)
            @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    // Stimulus
    initial begin
        cfg_first    = dcps_pkg::RST_FIRST_CODE;
        cfg_second   = dcps_pkg::RST_SECOND_CODE;
        cfg_timeout  = dcps_pkg::RST_DIGIT_TIMEOUT;
        cfg_inhibit  = dcps_pkg::RST_INHIBIT_DELAY;
        cfg_switch   = dcps_pkg::RST_SWITCH_DELAY;
        seq_phase    = SEQ_COLLECT;
        entry_digits = '0;
        entry_count  = '0;
        ticks_seen   = '0;
        aim_second   = 1'b0;
        line_bits    = dcps_pkg::RST_LINES;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (OPENING[k])
            send_item(OPENING[k].cmd, OPENING[k].dig, OPENING[k].typed, OPENING[k].want);

        // reset values, then zero delays, then both codes equal
        run_traffic(230);
        settle(draw_code(), draw_code(), 8'd3, 8'd0, 8'd0);
        run_traffic(230);
        settle(cfg_first, cfg_first, 8'd1, 8'd2, 8'd1);
        begin
            logic [dcps_pkg::CODE_W-1:0] shared;
            shared = draw_code();
            settle(shared, shared, 8'd1, 8'd2, 8'd1);
        end
        run_traffic(200);

        // extremes of the registers, including a zero timeout
        settle(20'hFFFFF, draw_code(), 8'd255, 8'd255, 8'd0);
        run_traffic(250);
        settle(20'h00000, draw_code(), 8'd0, 8'd0, 8'd255);
        run_traffic(200);

        // small random settings for the rest
        while (steps_done < TARGET_ITEMS) begin
            settle(draw_code(), draw_code(), 8'($urandom_range(1, 8)),
                   8'($urandom_range(4)), 8'($urandom_range(4)));
            run_traffic(90);
        end

        drain_stream();
        if (fault_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/dcps_pkg.sv
rtl/dcps_cfg.sv
rtl/dcps_seq.sv
rtl/dtmf_code_polarity_switch_core.sv
verif/testbench.sv
